// ===== hdl/shadc_pkg.sv =====
// Shared types, round constants and the SHA-256 round function for the
// differential cascade check. No dependencies.
package shadc_pkg;

	localparam int unsigned NumRounds   = 15;
	localparam int unsigned AdiffRound  = 12;
	localparam int unsigned W9Round     = 9;
	localparam logic [31:0] FirstWordRst = 32'hc5bde324;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] state_t;   // [0]=a ... [7]=h

	typedef struct packed {
		logic   valid;
		word_t  cand;
		state_t st_n;
		state_t st_f;
		word_t  dlt;
		word_t  adiff;
		word_t  w9;
	} pipe_t;

	localparam word_t RoundK [16] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174
	};

	localparam state_t InitH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// One compression round
	function automatic state_t round_f(input state_t s, input word_t k, input word_t w);
		word_t  s1, ch, t1, s0, mj, t2;
		state_t r;
		s1 = rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25);
		ch = (s[4] & s[5]) ^ (~s[4] & s[6]);
		t1 = s[7] + s1 + ch + k + w;
		s0 = rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22);
		mj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
		t2 = s0 + mj;
		r[7] = s[6];
		r[6] = s[5];
		r[5] = s[4];
		r[4] = s[3] + t1;
		r[3] = s[2];
		r[2] = s[1];
		r[1] = s[0];
		r[0] = t1 + t2;
		round_f = r;
	endfunction

endpackage

// ===== hdl/sha256_differential_cascade_check.sv =====
// Top level of the SHA-256 differential cascade check: config register,
// fifteen round stages and the final difference stage. Uses shadc_pkg, shadc_stage.
//
// Usage:
//   Request channel: raise start with candidate_word; the request is taken
//   on every edge where start is high and busy is low. busy is always low,
//   so a new candidate may enter in every cycle.
//   Config: first_word_we with first_word loads the fixed first message word;
//   change it only while no request is in flight.
//   Result channel: done pulses for one cycle with final_difference, hit and
//   tested_word; the request passes one stage per SHA-256 round, rounds 0
//   to 14, then one stage for the word-16 sum, before done rises.
//   Throughput is one candidate per cycle, set by the one-round-per-stage
//   pipeline.
//   Reset clears all stage valid bits, so no result appears until a request
//   has passed through; first_word returns to 0xc5bde324.
//   The receiver cannot hold results off; results are never stalled.
module sha256_differential_cascade_check
	import shadc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] candidate_word,
	input  logic        first_word_we,
	input  logic [31:0] first_word,
	output logic        done,
	output logic [31:0] final_difference,
	output logic        hit,
	output logic [31:0] tested_word
);

	word_t first_word_q;
	pipe_t pin  [NumRounds];
	pipe_t pout [NumRounds];
	word_t fin_s16;
	word_t cand_s16;
	logic  vld_s16;

	assign busy = 1'b0;

	// Hold the first message word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_word_q <= FirstWordRst;
		end else if (first_word_we) begin
			first_word_q <= first_word;
		end
	end

	// Stage inputs: fresh request at stage 0, capture a and w9 differences
	always_comb begin
		pin[0].valid = start & ~busy;
		pin[0].cand  = candidate_word;
		pin[0].st_n  = InitH;
		pin[0].st_f  = InitH;
		pin[0].dlt   = '0;
		pin[0].adiff = '0;
		pin[0].w9    = '0;
		for (int i = 1; i < NumRounds; i++) begin
			pin[i] = pout[i-1];
			if (i == AdiffRound + 1) begin
				pin[i].adiff = pout[i-1].st_f[0] - pout[i-1].st_n[0];
			end
			if (i == W9Round + 1) begin
				pin[i].w9 = pout[i-1].dlt;
			end
		end
	end

	// Round stages
	for (genvar r = 0; r < NumRounds; r++) begin : g_round
		word_t mn, mf;
		if (r == 0) begin : g_w0
			assign mn = first_word_q;
			assign mf = first_word_q + 32'd1;
		end else if (r == 1) begin : g_w1
			assign mn = pin[r].cand;
			assign mf = pin[r].cand;
		end else begin : g_wz
			assign mn = '0;
			assign mf = '0;
		end
		shadc_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.k       (RoundK[r]),
			.msg_n   (mn),
			.msg_f   (mf),
			.cascade (r >= 2),
			.pin     (pin[r]),
			.pout    (pout[r])
		);
	end

	// Final difference: the a difference after round 12 plus the word-16 difference sigma1(d14) + d9 + d0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
		end else begin
			vld_s16 <= pout[NumRounds-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		fin_s16  <= pout[NumRounds-1].adiff + ssig1(pout[NumRounds-1].dlt)
			+ pout[NumRounds-1].w9 + 32'd1;
		cand_s16 <= pout[NumRounds-1].cand;
	end

	assign done             = vld_s16;
	assign final_difference = fin_s16;
	assign hit              = (fin_s16 == '0);
	assign tested_word      = cand_s16;

endmodule

// ===== hdl/shadc_stage.sv =====
// One pipeline stage: a round of the normal and the faulted chain, with the
// cascade correction that cancels the e difference. Uses shadc_pkg.
module shadc_stage
	import shadc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  word_t k,
	input  word_t msg_n,
	input  word_t msg_f,
	input  logic  cascade,
	input  pipe_t pin,
	output pipe_t pout
);

	state_t tn, tf;
	word_t  d;
	pipe_t  nxt_s1;

	// Run both rounds, then fold the e difference into faulted a and e
	always_comb begin
		tn = round_f(pin.st_n, k, msg_n);
		tf = round_f(pin.st_f, k, msg_f);
		d  = cascade ? (tn[4] - tf[4]) : '0;
		nxt_s1       = pin;
		nxt_s1.st_n  = tn;
		nxt_s1.st_f  = tf;
		nxt_s1.st_f[0] = tf[0] + d;
		nxt_s1.st_f[4] = tf[4] + d;
		nxt_s1.dlt   = d;
	end

	// Advance the valid bit and the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pout <= '0;
		end else begin
			pout <= nxt_s1;
		end
	end

endmodule
